/* rtl/pwl_pkg.sv */
// Shared types and constants of the piecewise linear interpolator.
// No dependencies; the interfaces and the top level use it by scoped names.
package pwl_pkg;

    // Fixed field widths
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int STATUS_W = 2;

    // Reset value of the point count register
    localparam logic [CNT_W-1:0] CNT_RESET = 7'd2;

    // Function codes of an input beat
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Status codes of a result beat
    localparam logic [STATUS_W-1:0] STAT_INSIDE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BELOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ABOVE  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DEGEN  = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEL,
        ST_FETCH0,
        ST_FETCH1,
        ST_DIFF,
        ST_MUL,
        ST_DCHK,
        ST_DIV,
        ST_SUM,
        ST_PUSH
    } t_state;

endpackage

/* rtl/pwl_if.sv */
// Valid/ready channel interfaces for input beats and result beats.
// Depends on pwl_pkg for the fixed field widths.
interface pwl_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [pwl_pkg::IDX_W-1:0]     entry_index;
    logic signed [DATA_WIDTH-1:0]  position;
    logic signed [DATA_WIDTH-1:0]  sample_value;
    logic                          end_of_batch;

    modport source (
        output valid, func, entry_index, position, sample_value, end_of_batch,
        input  ready
    );
    modport sink (
        input  valid, func, entry_index, position, sample_value, end_of_batch,
        output ready
    );
endinterface

interface pwl_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [DATA_WIDTH-1:0]  interpolated;
    logic [pwl_pkg::STATUS_W-1:0]  status;
    logic                          last_of_batch;

    modport source (
        output valid, interpolated, status, last_of_batch,
        input  ready
    );
    modport sink (
        input  valid, interpolated, status, last_of_batch,
        output ready
    );
endinterface

/* rtl/pwl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/piecewise_linear_interp.sv */
// Piecewise linear interpolator over a breakpoint table held in two RAMs.
// Depends on pwl_pkg, pwl_in_if / pwl_out_if and pwl_ram.
//
//  channel   dir  handshake     payload
//  i_item    in   valid/ready   func, entry_index, position, sample_value, end_of_batch
//  o_result  out  valid/ready   interpolated, status, last_of_batch
//  i_cfg_*   in   write enable  point_count
//
// A load beat is written into both RAMs as it is taken. A query first scans the
// n breakpoints, n being the clamped point count, one per cycle over the x RAM
// read port, then runs the difference steps and bit-serial multiply and divide
// steps on the one shared adder/subtractor.
// Reset (synchronous, active low) clears the sequencer and the result valid and
// sets the point count to 2; the table holds nothing defined until loaded. The
// result sits in an output register, so the next beat is taken while it waits; a
// finished query holds in its last state while that register is still full.
module piecewise_linear_interp #(
    parameter int MAX_POINTS = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pwl_in_if.sink                     i_item,
    pwl_out_if.source                  o_result,
    input  logic                       i_cfg_wr_en,
    input  logic [pwl_pkg::CNT_W-1:0]  i_cfg_wr_data
);

    localparam int DW  = DATA_WIDTH;
    localparam int W   = DW + 1;                  // difference width
    localparam int UW  = W + 2;                   // shared unit width
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = (AW + 1 > pwl_pkg::CNT_W) ? AW + 1 : pwl_pkg::CNT_W;
    localparam int IW  = (AW + 1 > pwl_pkg::IDX_W) ? AW + 1 : pwl_pkg::IDX_W;
    localparam int SW  = $clog2(W);

    // Difference and magnitude steps
    localparam logic [2:0] OP_DT  = 3'd0;
    localparam logic [2:0] OP_DY  = 3'd1;
    localparam logic [2:0] OP_DX  = 3'd2;
    localparam logic [2:0] OP_MDT = 3'd3;
    localparam logic [2:0] OP_MDY = 3'd4;
    localparam logic [2:0] OP_MDX = 3'd5;

    pwl_pkg::t_state r_state, n_state;

    logic [pwl_pkg::CNT_W-1:0]    r_point_count;
    logic [AW-1:0]                r_idx;
    logic [AW-1:0]                r_seg;
    logic                         r_found;
    logic                         r_g0;
    logic                         r_gprev;
    logic [DW-1:0]                r_t;
    logic                         r_last;
    logic [pwl_pkg::STATUS_W-1:0] r_stat;
    logic [DW-1:0]                r_x0, r_y0, r_x1, r_y1;
    logic [W-1:0]                 r_dt, r_dy, r_dx;
    logic                         r_neg;
    logic [2*W-1:0]               r_pq;
    logic [W-1:0]                 r_rem;
    logic                         r_ovf;
    logic [SW-1:0]                r_cnt;
    logic [DW-1:0]                r_val;

    logic                         r_ovalid;
    logic [DW-1:0]                r_oval;
    logic [pwl_pkg::STATUS_W-1:0] r_ostat;
    logic                         r_olast;

    logic                         in_ready;
    logic                         in_fire;
    logic                         out_free;
    logic                         push;

    logic [CW-1:0]                cnt_ext, n_pts, n_m1, n_m2;
    logic [AW-1:0]                last_idx, seg_max;
    logic [IW-1:0]                idx_ext;
    logic                         ram_we;
    logic [AW-1:0]                ram_raddr;
    logic [DW-1:0]                x_rdata, y_rdata;

    logic [UW-1:0]                u_a, u_b, u_res;
    logic                         u_sub;
    logic                         u_negative;

    logic [AW-1:0]                sel_seg;
    logic [pwl_pkg::STATUS_W-1:0] sel_stat;
    logic [W-1:0]                 pq_hi;
    logic [W:0]                   mul_sum;
    logic [W:0]                   div_sh;
    logic                         div_bit;
    logic [W:0]                   q_mag;
    logic [DW-1:0]                sat_val;

    // Clamp the point count to the table size
    always_comb begin
        cnt_ext = CW'(r_point_count);
        if (cnt_ext < CW'(2)) begin
            n_pts = CW'(2);
        end else if (cnt_ext > CW'(MAX_POINTS)) begin
            n_pts = CW'(MAX_POINTS);
        end else begin
            n_pts = cnt_ext;
        end
        n_m1     = n_pts - CW'(1);
        n_m2     = n_pts - CW'(2);
        last_idx = n_m1[AW-1:0];
        seg_max  = n_m2[AW-1:0];
    end

    // Handshake and table write
    assign in_fire  = i_item.valid && in_ready;
    assign out_free = !r_ovalid || o_result.ready;
    assign idx_ext  = IW'(i_item.entry_index);
    assign ram_we   = in_fire && (i_item.func == pwl_pkg::FUNC_LOAD)
                      && (idx_ext < IW'(MAX_POINTS));

    pwl_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (idx_ext[AW-1:0]),
        .i_wr_data (i_item.position),
        .i_rd_addr (ram_raddr),
        .o_rd_data (x_rdata)
    );

    pwl_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (idx_ext[AW-1:0]),
        .i_wr_data (i_item.sample_value),
        .i_rd_addr (ram_raddr),
        .o_rd_data (y_rdata)
    );

    // Segment choice once the scan is over
    always_comb begin
        if (r_found) begin
            sel_seg  = r_seg;
            sel_stat = pwl_pkg::STAT_INSIDE;
        end else if (!r_g0) begin
            sel_seg  = '0;
            sel_stat = pwl_pkg::STAT_BELOW;
        end else begin
            sel_seg  = seg_max;
            sel_stat = pwl_pkg::STAT_ABOVE;
        end
    end

    // Shared adder/subtractor
    assign u_res      = u_a + (u_sub ? ~u_b : u_b) + UW'(u_sub);
    assign u_negative = u_res[UW-1];

    assign pq_hi   = r_pq[2*W-1:W];
    assign mul_sum = r_pq[0] ? u_res[W:0] : {1'b0, pq_hi};
    assign div_sh  = {r_rem, r_pq[W-1]};
    assign div_bit = !u_negative;
    assign q_mag   = r_ovf ? {1'b1, {W{1'b0}}} : {1'b0, r_pq[W-1:0]};

    // Saturate the final sum to the data width
    always_comb begin
        if (&u_res[UW-1:DW-1] || !(|u_res[UW-1:DW-1])) begin
            sat_val = u_res[DW-1:0];
        end else if (u_negative) begin
            sat_val = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(DW-1){1'b1}}};
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pwl_pkg::ST_IDLE: begin
                if (in_fire && (i_item.func == pwl_pkg::FUNC_QUERY)) begin
                    n_state = pwl_pkg::ST_SCAN;
                end
            end
            pwl_pkg::ST_SCAN: begin
                if (r_idx == last_idx) begin
                    n_state = pwl_pkg::ST_SEL;
                end
            end
            pwl_pkg::ST_SEL:    n_state = pwl_pkg::ST_FETCH0;
            pwl_pkg::ST_FETCH0: n_state = pwl_pkg::ST_FETCH1;
            pwl_pkg::ST_FETCH1: n_state = pwl_pkg::ST_DIFF;
            pwl_pkg::ST_DIFF: begin
                if (r_cnt == SW'(OP_MDX)) begin
                    n_state = (r_dx == '0) ? pwl_pkg::ST_PUSH : pwl_pkg::ST_MUL;
                end
            end
            pwl_pkg::ST_MUL: begin
                if (r_cnt == SW'(W - 1)) begin
                    n_state = pwl_pkg::ST_DCHK;
                end
            end
            pwl_pkg::ST_DCHK: begin
                n_state = u_negative ? pwl_pkg::ST_DIV : pwl_pkg::ST_SUM;
            end
            pwl_pkg::ST_DIV: begin
                if (r_cnt == SW'(W - 1)) begin
                    n_state = pwl_pkg::ST_SUM;
                end
            end
            pwl_pkg::ST_SUM: n_state = pwl_pkg::ST_PUSH;
            pwl_pkg::ST_PUSH: begin
                if (out_free) begin
                    n_state = pwl_pkg::ST_IDLE;
                end
            end
            default: n_state = pwl_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: ready, push, read address, shared unit operands
    always_comb begin
        in_ready  = 1'b0;
        push      = 1'b0;
        ram_raddr = '0;
        u_a       = '0;
        u_b       = '0;
        u_sub     = 1'b0;
        unique case (r_state)
            pwl_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            pwl_pkg::ST_SCAN: begin
                ram_raddr = r_idx + AW'(1);
                u_a       = {{(UW-DW){x_rdata[DW-1]}}, x_rdata};
                u_b       = {{(UW-DW){r_t[DW-1]}}, r_t};
                u_sub     = 1'b1;
            end
            pwl_pkg::ST_SEL: begin
                ram_raddr = sel_seg;
            end
            pwl_pkg::ST_FETCH0: begin
                ram_raddr = r_seg + AW'(1);
            end
            pwl_pkg::ST_FETCH1: begin
                ram_raddr = r_seg + AW'(1);
            end
            pwl_pkg::ST_DIFF: begin
                u_sub = 1'b1;
                case (r_cnt[2:0])
                    OP_DT: begin
                        u_a = {{(UW-DW){r_t[DW-1]}}, r_t};
                        u_b = {{(UW-DW){r_x0[DW-1]}}, r_x0};
                    end
                    OP_DY: begin
                        u_a = {{(UW-DW){r_y0[DW-1]}}, r_y0};
                        u_b = {{(UW-DW){r_y1[DW-1]}}, r_y1};
                    end
                    OP_DX: begin
                        u_a = {{(UW-DW){r_x0[DW-1]}}, r_x0};
                        u_b = {{(UW-DW){r_x1[DW-1]}}, r_x1};
                    end
                    OP_MDT:  u_b = {{(UW-W){r_dt[W-1]}}, r_dt};
                    OP_MDY:  u_b = {{(UW-W){r_dy[W-1]}}, r_dy};
                    OP_MDX:  u_b = {{(UW-W){r_dx[W-1]}}, r_dx};
                    default: u_b = '0;
                endcase
            end
            pwl_pkg::ST_MUL: begin
                u_a = UW'(pq_hi);
                u_b = UW'(r_dt);
            end
            pwl_pkg::ST_DCHK: begin
                u_a   = UW'(pq_hi);
                u_b   = UW'(r_dx);
                u_sub = 1'b1;
            end
            pwl_pkg::ST_DIV: begin
                u_a   = UW'(div_sh);
                u_b   = UW'(r_dx);
                u_sub = 1'b1;
            end
            pwl_pkg::ST_SUM: begin
                u_a   = {{(UW-DW){r_y0[DW-1]}}, r_y0};
                u_b   = UW'(q_mag);
                u_sub = r_neg;
            end
            pwl_pkg::ST_PUSH: begin
                push = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= pwl_pkg::ST_IDLE;
            r_point_count <= pwl_pkg::CNT_RESET;
            r_ovalid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_point_count <= i_cfg_wr_data;
            end
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pwl_pkg::ST_IDLE: begin
                // capture the query
                r_idx   <= '0;
                r_found <= 1'b0;
                r_t     <= i_item.position;
                r_last  <= i_item.end_of_batch;
            end
            pwl_pkg::ST_SCAN: begin
                // t above x[idx]; a fall from above to not above closes a segment
                if (r_idx == '0) begin
                    r_g0 <= u_negative;
                end else if (r_gprev && !u_negative) begin
                    r_seg   <= r_idx - AW'(1);
                    r_found <= 1'b1;
                end
                r_gprev <= u_negative;
                r_idx   <= r_idx + AW'(1);
            end
            pwl_pkg::ST_SEL: begin
                r_seg  <= sel_seg;
                r_stat <= sel_stat;
            end
            pwl_pkg::ST_FETCH0: begin
                r_x0 <= x_rdata;
                r_y0 <= y_rdata;
            end
            pwl_pkg::ST_FETCH1: begin
                r_x1  <= x_rdata;
                r_y1  <= y_rdata;
                r_cnt <= '0;
            end
            pwl_pkg::ST_DIFF: begin
                // advance the step, restart it for the multiply after the last one
                if (r_cnt[2:0] == OP_MDX) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + SW'(1);
                end
                case (r_cnt[2:0])
                    OP_DT: r_dt <= u_res[W-1:0];
                    OP_DY: r_dy <= u_res[W-1:0];
                    OP_DX: r_dx <= u_res[W-1:0];
                    OP_MDT: begin
                        r_neg <= r_dt[W-1] ^ r_dy[W-1] ^ r_dx[W-1];
                        if (r_dt[W-1]) begin
                            r_dt <= u_res[W-1:0];
                        end
                    end
                    OP_MDY: begin
                        if (r_dy[W-1]) begin
                            r_dy <= u_res[W-1:0];
                        end
                    end
                    OP_MDX: begin
                        if (r_dx[W-1]) begin
                            r_dx <= u_res[W-1:0];
                        end
                        // load the multiplier, or drop to a zero result on equal x
                        r_pq <= {{W{1'b0}}, r_dy};
                        if (r_dx == '0) begin
                            r_val  <= '0;
                            r_stat <= pwl_pkg::STAT_DEGEN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            pwl_pkg::ST_MUL: begin
                // shift-add step, multiplier bits from the low end
                r_pq  <= {mul_sum, r_pq[W-1:1]};
                r_cnt <= r_cnt + SW'(1);
            end
            pwl_pkg::ST_DCHK: begin
                // high half not below the divisor: quotient overflows
                r_ovf <= !u_negative;
                r_rem <= pq_hi;
                r_cnt <= '0;
            end
            pwl_pkg::ST_DIV: begin
                // restoring divide step, one quotient bit per cycle
                if (div_bit) begin
                    r_rem <= u_res[W-1:0];
                end else begin
                    r_rem <= div_sh[W-1:0];
                end
                r_pq[W-1:0] <= {r_pq[W-2:0], div_bit};
                r_cnt       <= r_cnt + SW'(1);
            end
            pwl_pkg::ST_SUM: begin
                r_val <= sat_val;
            end
            pwl_pkg::ST_PUSH: begin
                if (push) begin
                    r_oval  <= r_val;
                    r_ostat <= r_stat;
                    r_olast <= r_last;
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    // Drive the ports
    assign i_item.ready           = in_ready;
    assign o_result.valid         = r_ovalid;
    assign o_result.interpolated  = r_oval;
    assign o_result.status        = r_ostat;
    assign o_result.last_of_batch = r_olast;

endmodule

/* dv/tb_piecewise_linear_interp.sv */
`timescale 1ns / 100ps
// Self-checking testbench of piecewise_linear_interp: loads breakpoint tables,
// queries them under random handshake pressure and checks every result beat.
// Depends on pwl_pkg, pwl_in_if / pwl_out_if and the piecewise_linear_interp RTL.
module tb_piecewise_linear_interp;

    localparam int          NPTS       = 64;
    localparam int          DW         = 32;
    localparam int          SETTLE     = 160;
    localparam int          WATCHDOG   = 4000;
    localparam int          SQUEEZE    = 800;
    localparam longint      SAT_HI     = 64'sd2147483647;
    localparam longint      SAT_LO     = -64'sd2147483648;
    localparam logic [31:0] MIN32      = 32'h8000_0000;
    localparam logic [31:0] MAX32      = 32'h7FFF_FFFF;

    typedef struct packed {
        logic                           func;
        logic [pwl_pkg::IDX_W-1:0]      idx;
        logic signed [DW-1:0]           pos;
        logic signed [DW-1:0]           sval;
        logic                           eob;
    } t_beat;

    typedef struct packed {
        logic signed [DW-1:0]           interp;
        logic [pwl_pkg::STATUS_W-1:0]   status;
        logic                           last;
    } t_interp;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    t_beat                     in_beat   = '0;
    logic                      out_ready = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [pwl_pkg::CNT_W-1:0] cfg_data  = '0;

    pwl_in_if  #(.DATA_WIDTH(DW)) item_if ();
    pwl_out_if #(.DATA_WIDTH(DW)) res_if ();

    assign item_if.valid        = in_valid;
    assign item_if.func         = in_beat.func;
    assign item_if.entry_index  = in_beat.idx;
    assign item_if.position     = in_beat.pos;
    assign item_if.sample_value = in_beat.sval;
    assign item_if.end_of_batch = in_beat.eob;
    assign res_if.ready         = out_ready;

    piecewise_linear_interp #(.MAX_POINTS(NPTS), .DATA_WIDTH(DW)) uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_item        (item_if),
        .o_result      (res_if),
        .i_cfg_wr_en   (cfg_we),
        .i_cfg_wr_data (cfg_data)
    );

    // Toggle the clock, 10 ns period
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: breakpoint copy and point count as the block sees them
    logic signed [DW-1:0]      bp_x [NPTS];
    logic signed [DW-1:0]      bp_y [NPTS];
    logic [pwl_pkg::CNT_W-1:0] bp_count = pwl_pkg::CNT_RESET;

    // Generator view of the table after every queued beat
    logic signed [DW-1:0] plan_x [NPTS];

    t_beat   beat_backlog [$];
    t_interp interp_due [$];
    int      beats_queued = 0;
    int      beats_sent = 0;
    int      errors = 0;
    int      gap_pct = 0;
    int      stall_pct = 0;
    bit      calm = 1'b0;
    int      squeeze_req = 0;
    int      squeeze_done = 0;

    // Clamp the point count to the breakpoints actually scanned
    function automatic int span_of(input logic [pwl_pkg::CNT_W-1:0] c);
        if (c < 2)
            return 2;
        if (c > NPTS)
            return NPTS;
        return int'(c);
    endfunction

    // Interpolate along the selected segment, truncate and saturate
    function automatic t_interp predict_interp(input logic signed [DW-1:0] t,
                                               input logic eob);
        t_interp      res;
        int           n, k, seg;
        bit           hit, neg;
        longint       x0, x1, y0, y1, dt, dy, dx, q, s;
        logic [63:0]  mag_t, mag_y, mag_x;
        logic [127:0] quo;
        n = span_of(bp_count);
        seg = 0;
        hit = 1'b0;
        res.last = eob;
        for (k = 0; k + 1 < n; k++) begin
            if (t > bp_x[k] && t <= bp_x[k+1]) begin
                seg = k;
                hit = 1'b1;
            end
        end
        if (hit) begin
            res.status = pwl_pkg::STAT_INSIDE;
        end else if (t <= bp_x[0]) begin
            seg = 0;
            res.status = pwl_pkg::STAT_BELOW;
        end else begin
            seg = n - 2;
            res.status = pwl_pkg::STAT_ABOVE;
        end
        x0 = bp_x[seg];
        x1 = bp_x[seg+1];
        y0 = bp_y[seg];
        y1 = bp_y[seg+1];
        if (x0 == x1) begin
            res.interp = '0;
            res.status = pwl_pkg::STAT_DEGEN;
        end else begin
            dt = longint'(t) - x0;
            dy = y0 - y1;
            dx = x0 - x1;
            neg = ((dt < 0) != (dy < 0)) != (dx < 0);
            mag_t = (dt < 0) ? -dt : dt;
            mag_y = (dy < 0) ? -dy : dy;
            mag_x = (dx < 0) ? -dx : dx;
            quo = ({64'd0, mag_t} * {64'd0, mag_y}) / {64'd0, mag_x};
            // clamp the quotient magnitude at 2^62 before the sum
            if (quo > 128'h4000_0000_0000_0000)
                q = 64'sh4000_0000_0000_0000;
            else
                q = longint'(quo[63:0]);
            if (neg)
                q = -q;
            s = y0 + q;
            if (s > SAT_HI)
                s = SAT_HI;
            if (s < SAT_LO)
                s = SAT_LO;
            res.interp = s[DW-1:0];
        end
        return res;
    endfunction

    function automatic void push_load(input int idx, input logic signed [DW-1:0] x,
                                      input logic signed [DW-1:0] y, input logic eob);
        t_beat b;
        b.func = pwl_pkg::FUNC_LOAD;
        b.idx  = idx[pwl_pkg::IDX_W-1:0];
        b.pos  = x;
        b.sval = y;
        b.eob  = eob;
        beat_backlog.push_back(b);
        plan_x[idx] = x;
        beats_queued++;
    endfunction

    function automatic void push_query(input logic signed [DW-1:0] t, input logic eob);
        t_beat b;
        b.func = pwl_pkg::FUNC_QUERY;
        b.idx  = pwl_pkg::IDX_W'($urandom);
        b.pos  = t;
        b.sval = $urandom;
        b.eob  = eob;
        beat_backlog.push_back(b);
        beats_queued++;
    endfunction

    function automatic logic signed [DW-1:0] rand_between(input longint lo, input longint hi);
        logic [63:0] r, span;
        r = {$urandom, $urandom};
        span = hi - lo + 1;
        return DW'(lo + longint'(r % span));
    endfunction

    function automatic logic signed [DW-1:0] rand_y(input int style);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return MIN32;
        if (r == 1)
            return MAX32;
        if (style == 1 || style == 2)
            return DW'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
        return $urandom;
    endfunction

    // Build a table of nn points in shuffled load order.
    // Styles: 0 sorted full range, 1 sorted fine steps, 2 sorted with repeats,
    // 3 unsorted, 4 tightly packed x under wide y spans (quotient clamp).
    function automatic void load_table(input int nn, input int style);
        int xs [$];
        int order [NPTS];
        int k, j, tmp, x;
        x = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        for (k = 0; k < nn; k++) begin
            case (style)
                0, 3: begin
                    xs.push_back($urandom);
                end
                1: begin
                    xs.push_back(x);
                    x += $urandom_range(1, 1 << 17);
                end
                2: begin
                    xs.push_back(x);
                    x += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 16);
                end
                default: begin
                    xs.push_back(x);
                    x += $urandom_range(0, 2);
                end
            endcase
        end
        if (style != 3)
            xs.sort();
        for (k = 0; k < nn; k++)
            order[k] = k;
        for (k = nn - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (k = 0; k < nn; k++)
            push_load(order[k], xs[order[k]], rand_y(style), 1'($urandom_range(0, 1)));
        // a stray write beyond the points in use
        if (nn < NPTS && $urandom_range(0, 1) == 1)
            push_load($urandom_range(nn, NPTS - 1), $urandom, $urandom,
                      1'($urandom_range(0, 1)));
    endfunction

    // Pick a query position: most often inside segments, on knots and off both ends
    function automatic logic signed [DW-1:0] pick_position(input int nn);
        int     r, k;
        longint lo, hi;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, nn - 2);
        if (r < 45) begin
            lo = longint'(plan_x[k]) + 1;
            hi = plan_x[k+1];
            return (lo <= hi) ? rand_between(lo, hi) : plan_x[k];
        end
        if (r < 60)
            return plan_x[$urandom_range(0, nn - 1)];
        if (r < 70)
            return rand_between(SAT_LO, plan_x[0]);
        if (r < 80)
            return rand_between(plan_x[nn-1], SAT_HI);
        if (r < 92)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return MIN32;
            1: return MAX32;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    task automatic write_count(input logic [pwl_pkg::CNT_W-1:0] c);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we   <= 1'b0;
        bp_count = c;
    endtask

    // Wait until every queued beat is taken and every result is back, then settle
    task automatic drain();
        while (beats_sent != beats_queued || interp_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(input logic [pwl_pkg::CNT_W-1:0] c, input int beats);
        int nn, target, r;
        write_count(c);
        nn = span_of(c);
        target = beats_queued + beats;
        load_table(nn, $urandom_range(0, 4));
        while (beats_queued < target) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                load_table(nn, $urandom_range(0, 4));
            else if (r < 10)
                push_load($urandom_range(0, nn - 1), $urandom, rand_y(0),
                          1'($urandom_range(0, 1)));
            else
                push_query(pick_position(nn), $urandom_range(0, 3) == 0);
        end
    endtask

    // Stimulus sequence
    initial begin
        logic [pwl_pkg::CNT_W-1:0] counts [10];
        int p;
        counts = '{7'd64, 7'd5, 7'd0, 7'd127, 7'd3, 7'd1, 7'd20, 7'd65, 7'd2, 7'd64};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two-point table at the reset count: ends, knots, extremes
        gap_pct = 20;
        stall_pct = 20;
        push_load(0, 32'h0000_0000, 32'h0000_0000, 1'b0);
        push_load(1, 32'h0001_0000, 32'h0003_0000, 1'b1);
        push_query(32'h0000_0000, 1'b0);
        push_query(32'h0000_8000, 1'b0);
        push_query(32'h0001_0000, 1'b0);
        push_query(32'h0002_0000, 1'b1);
        push_query(MIN32, 1'b0);
        push_query(MAX32, 1'b1);
        // equal x on both knots
        push_load(1, 32'h0000_0000, 32'h0005_0000, 1'b0);
        push_query(32'h0000_0007, 1'b1);
        // unit x step under a full y swing: quotient clamp and sum saturation
        push_load(0, MIN32, MIN32, 1'b0);
        push_load(1, MIN32 + 1, MAX32, 1'b0);
        push_query(MAX32, 1'b0);
        push_query(MIN32, 1'b1);
        // descending knots
        push_load(0, MAX32, MAX32, 1'b1);
        push_load(1, MIN32, MIN32, 1'b0);
        push_query(32'h0000_0000, 1'b1);
        push_query(32'hFFFF_FFFF, 1'b0);
        drain();

        for (p = 0; p < 10; p++) begin
            gap_pct   = (p % 3 == 1) ? 0 : 20;
            stall_pct = (p % 4 == 2) ? 0 : 25;
            if (p == 9)
                calm = 1'b1;
            // hold the receiver off so the block fills up and stalls its input
            if (p == 0)
                squeeze_req++;
            run_phase(counts[p], 185);
            drain();
        end

        if (errors == 0 && interp_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Drive input beats from the backlog, with random idle bursts
    always @(posedge clk) begin
        logic  nv;
        t_beat nb;
        int    gap_left;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            nv = in_valid;
            nb = in_beat;
            if (in_valid && item_if.ready) begin
                if (in_beat.func == pwl_pkg::FUNC_LOAD) begin
                    bp_x[in_beat.idx] = in_beat.pos;
                    bp_y[in_beat.idx] = in_beat.sval;
                end else begin
                    interp_due.push_back(predict_interp(in_beat.pos, in_beat.eob));
                end
                beats_sent++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (beat_backlog.size() != 0) begin
                    if (!calm && $urandom_range(0, 99) < gap_pct) begin
                        gap_left = $urandom_range(0, 5);
                    end else begin
                        nb = beat_backlog.pop_front();
                        nv = 1'b1;
                    end
                end
            end
            in_valid <= nv;
            in_beat  <= nb;
        end
    end

    // Drive result ready: random stall bursts and one long hold-off
    always @(posedge clk) begin
        int stall_left;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else if (squeeze_done != squeeze_req) begin
            squeeze_done = squeeze_req;
            stall_left = SQUEEZE - 1;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 5);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge clk) begin
        t_interp want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (interp_due.size() == 0) begin
                $error("result beat with no query outstanding: interpolated %0d status %0d",
                       res_if.interpolated, res_if.status);
                errors++;
            end else begin
                want = interp_due.pop_front();
                if (res_if.interpolated !== want.interp) begin
                    $error("interpolated: expected %0d, got %0d",
                           want.interp, res_if.interpolated);
                    errors++;
                end
                if (res_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_if.status);
                    errors++;
                end
                if (res_if.last_of_batch !== want.last) begin
                    $error("last_of_batch: expected %0d, got %0d",
                           want.last, res_if.last_of_batch);
                    errors++;
                end
            end
        end
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge clk) begin
        int quiet_cycles;
        if (!rst_n || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

endmodule

/* files.f */
rtl/pwl_pkg.sv
rtl/pwl_if.sv
rtl/pwl_ram.sv
rtl/piecewise_linear_interp.sv
dv/tb_piecewise_linear_interp.sv
